FILE: hw/rtl/lcfb_pkg.sv
package lcfb_pkg;

  // Field widths.
  localparam int unsigned FocusW     = 16;
  localparam int unsigned CurrentW   = 10;
  localparam int unsigned CodeW      = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned FrameIdxW  = 4;

  // Divider: two quotient bits per cycle over a 16-bit quotient.
  localparam int unsigned DivBitsPerCycle = 2;
  localparam int unsigned DivCycles       = CodeW / DivBitsPerCycle;
  localparam int unsigned DivCntW         = $clog2(DivCycles);
  localparam int unsigned DividendW       = 2 * CodeW;

  // Action codes.
  localparam logic ActFocus   = 1'b0;
  localparam logic ActCurrent = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFocusMin  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFocusMax  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFullScale = 2'd2;

  // Register reset values.
  localparam logic [FocusW-1:0]   FocusMinReset  = 16'd23040;
  localparam logic [FocusW-1:0]   FocusMaxReset  = 16'd40960;
  localparam logic [CurrentW-1:0] FullScaleReset = 10'd293;

  // Focus code is 1000 + 51200000 / F. Any F below 794 gives a code above
  // 65535, so those values saturate and the quotient always fits 16 bits.
  localparam logic [DividendW-1:0] FocusNumerator = 32'd51200000;
  localparam logic [FocusW-1:0]    FocusSatBelow  = 16'd794;
  localparam logic [CodeW-1:0]     FocusOffset    = 16'd1000;
  localparam logic [CodeW-1:0]     CodeMax        = 16'hFFFF;

  // CRC-16/ARC, reflected polynomial.
  localparam logic [CodeW-1:0] CrcPoly = 16'hA001;

  // Frame lengths, and the count of bytes that the CRC covers.
  localparam logic [FrameIdxW-1:0] FocusLen    = 4'd10;
  localparam logic [FrameIdxW-1:0] CurrentLen  = 4'd6;
  localparam logic [FrameIdxW-1:0] FocusData   = 4'd8;
  localparam logic [FrameIdxW-1:0] CurrentData = 4'd4;

  typedef struct packed {
    logic [FocusW-1:0]   focus_min;
    logic [FocusW-1:0]   focus_max;
    logic [CurrentW-1:0] full_scale;
  } lcfb_cfg_t;

  // One classified command waiting for the byte sequencer.
  typedef struct packed {
    logic             action;
    logic [CodeW-1:0] code;
  } lcfb_job_t;

  function automatic logic [FrameIdxW-1:0] frame_len(input logic action);
    return (action == ActCurrent) ? CurrentLen : FocusLen;
  endfunction

  function automatic logic [FrameIdxW-1:0] data_len(input logic action);
    return (action == ActCurrent) ? CurrentData : FocusData;
  endfunction

  // One byte of CRC-16/ARC, bit by bit.
  function automatic logic [CodeW-1:0] crc_update(input logic [CodeW-1:0] crc,
                                                  input logic [ByteW-1:0] data);
    logic [CodeW-1:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < ByteW; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Frame byte at position idx in send order.
  function automatic logic [ByteW-1:0] frame_byte(input logic action,
                                                  input logic [FrameIdxW-1:0] idx,
                                                  input logic [CodeW-1:0] code,
                                                  input logic [CodeW-1:0] crc);
    logic [ByteW-1:0] b;
    b = 8'h00;
    if (action == ActCurrent) begin
      case (idx)
        4'd0:    b = 8'h41;
        4'd1:    b = 8'h77;
        4'd2:    b = code[15:8];
        4'd3:    b = code[7:0];
        4'd4:    b = crc[7:0];
        4'd5:    b = crc[15:8];
        default: b = 8'h00;
      endcase
    end else begin
      case (idx)
        4'd0:    b = 8'h50;
        4'd1:    b = 8'h77;
        4'd2:    b = 8'h44;
        4'd3:    b = 8'h41;
        4'd4:    b = code[15:8];
        4'd5:    b = code[7:0];
        4'd8:    b = crc[7:0];
        4'd9:    b = crc[15:8];
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

FILE: hw/rtl/lcfb_intf.sv
// Command channel: one beat per frame request.
interface lcfb_cmd_if;
  import lcfb_pkg::*;
  logic                valid;
  logic                ready;
  logic                action;
  logic [FocusW-1:0]   focus_q8;
  logic [CurrentW-1:0] current_ma;

  modport source (output valid, action, focus_q8, current_ma, input ready);
  modport sink   (input valid, action, focus_q8, current_ma, output ready);
endinterface

// Frame channel: one beat per frame byte.
interface lcfb_frame_if;
  import lcfb_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] frame_byte;
  logic             last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

FILE: hw/rtl/lcfb_front.sv
module lcfb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcfb_pkg::lcfb_cfg_t cfg_i,
  lcfb_cmd_if.sink           cmd_i,
  output logic               push_o,
  output lcfb_pkg::lcfb_job_t job_o,
  input  logic               push_ready_i
);
  import lcfb_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DivCntW-1:0]   step_q, step_d;
  logic                 act_q, sat_q;
  logic [CodeW-1:0]     rem_q, num_q, quo_q, den_q;
  logic [CodeW-1:0]     rem_nx, num_nx, quo_nx;
  logic                 accept;
  logic [FocusW-1:0]    f_clamp;
  logic                 sat_in;
  logic [DividendW-1:0] dividend;
  logic [CodeW-1:0]     den_in;

  // Take a new command unless the divider is busy or its result is stuck.
  assign cmd_i.ready = !busy_q && (!done_q || push_ready_i);
  assign accept      = cmd_i.valid && cmd_i.ready;

  // Clamp the focus with the upper limit tested first, then pick operands.
  always_comb begin
    if (cmd_i.focus_q8 > cfg_i.focus_max) begin
      f_clamp = cfg_i.focus_max;
    end else if (cmd_i.focus_q8 < cfg_i.focus_min) begin
      f_clamp = cfg_i.focus_min;
    end else begin
      f_clamp = cmd_i.focus_q8;
    end
    if (cmd_i.action == ActCurrent) begin
      // The code overflows 16 bits exactly when current >= 16 * full scale.
      sat_in   = {4'b0000, cmd_i.current_ma} >= {cfg_i.full_scale, 4'b0000};
      dividend = {10'd0, cmd_i.current_ma, 12'd0};
      den_in   = {6'd0, cfg_i.full_scale};
    end else begin
      sat_in   = f_clamp < FocusSatBelow;
      dividend = FocusNumerator;
      den_in   = f_clamp;
    end
  end

  // Two restoring division steps per cycle.
  always_comb begin
    logic [CodeW:0] t;
    logic [CodeW:0] den_ext;
    rem_nx  = rem_q;
    num_nx  = num_q;
    quo_nx  = quo_q;
    den_ext = {1'b0, den_q};
    for (int k = 0; k < DivBitsPerCycle; k++) begin
      t      = {rem_nx, num_nx[CodeW-1]};
      num_nx = num_nx << 1;
      if (t >= den_ext) begin
        rem_nx = CodeW'(t - den_ext);
        quo_nx = {quo_nx[CodeW-2:0], 1'b1};
      end else begin
        rem_nx = t[CodeW-1:0];
        quo_nx = {quo_nx[CodeW-2:0], 1'b0};
      end
    end
  end

  // Control sequencing of the divider.
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    if (done_q && push_ready_i) begin
      done_d = 1'b0;
    end
    if (busy_q) begin
      step_d = step_q + 1'b1;
      if (step_q == DivCntW'(DivCycles - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    if (accept) begin
      busy_d = 1'b1;
      step_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= cmd_i.action;
      sat_q <= sat_in;
      rem_q <= dividend[DividendW-1:CodeW];
      num_q <= dividend[CodeW-1:0];
      den_q <= den_in;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_nx;
      num_q <= num_nx;
      quo_q <= quo_nx;
    end
  end

  // Finished code toward the queue.
  assign push_o       = done_q;
  assign job_o.action = act_q;
  always_comb begin
    if (sat_q) begin
      job_o.code = CodeMax;
    end else if (act_q == ActCurrent) begin
      job_o.code = quo_q;
    end else begin
      job_o.code = quo_q + FocusOffset;
    end
  end

`ifndef SYNTHESIS
  // A busy divider never takes a new command.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> !cmd_i.ready)
    else $error("command taken while divider busy");
  // A result appears exactly the full number of steps after a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(done_q) |-> $past(busy_q) && $past(step_q) == DivCntW'(DivCycles - 1))
    else $error("divider result after wrong step count");
`endif

endmodule

FILE: hw/rtl/lcfb_queue.sv
module lcfb_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lcfb_pkg::lcfb_job_t push_data_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output lcfb_pkg::lcfb_job_t pop_data_o,
  input  logic               pop_i
);
  import lcfb_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  lcfb_job_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              full, empty, do_push, do_pop;

  assign full         = cnt_q == CntW'(Depth);
  assign empty        = cnt_q == '0;
  assign push_ready_o = !full;
  assign pop_valid_o  = !empty;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full;
  assign do_pop       = pop_i && !empty;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  // A code offered while the queue is full stays offered until there is room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (push_i && full) |=> push_i)
    else $error("code withdrawn while queue full");
  // The fill count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("queue count out of range");
`endif

endmodule

FILE: hw/rtl/lcfb_back.sv
module lcfb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  lcfb_pkg::lcfb_job_t q_data_i,
  output logic               pop_o,
  lcfb_frame_if.source       frame_o
);
  import lcfb_pkg::*;

  logic                 active_q, active_d;
  logic                 out_valid_q, out_valid_d;
  logic [FrameIdxW-1:0] idx_q, idx_d;
  logic [CodeW-1:0]     crc_q, crc_d;
  lcfb_job_t            job_q, job_d;
  logic [ByteW-1:0]     out_byte_q, out_byte_d;
  logic                 out_last_q, out_last_d;
  logic                 can_load, load, is_last;
  logic [ByteW-1:0]     cur_byte;

  assign frame_o.valid      = out_valid_q;
  assign frame_o.frame_byte = out_byte_q;
  assign frame_o.last_byte  = out_last_q;

  // The output register takes a byte when empty or being drained.
  assign can_load = !out_valid_q || frame_o.ready;
  assign load     = active_q && can_load;
  assign cur_byte = frame_byte(job_q.action, idx_q, job_q.code, crc_q);
  assign is_last  = idx_q == frame_len(job_q.action) - 1'b1;
  assign pop_o    = q_valid_i && (!active_q || (load && is_last));

  // Byte sequencer; the CRC runs over the data bytes as they go out.
  always_comb begin
    active_d    = active_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    job_d       = job_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_last_d  = is_last;
      idx_d       = idx_q + 1'b1;
      if (idx_q < data_len(job_q.action)) begin
        crc_d = crc_update(crc_q, cur_byte);
      end
      if (is_last) begin
        active_d = 1'b0;
      end
    end else if (frame_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      active_d = 1'b1;
      job_d    = q_data_i;
      idx_d    = '0;
      crc_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q      <= crc_d;
    job_q      <= job_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

`ifndef SYNTHESIS
  // The byte position stays inside the frame being sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   active_q |-> idx_q < frame_len(job_q.action))
    else $error("frame index past frame length");
  // After the last byte with nothing queued, the sequencer goes idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (load && is_last && !q_valid_i) |=> !active_q)
    else $error("sequencer did not finish frame");
`endif

endmodule

FILE: hw/rtl/lens_command_frame_builder.sv
// Channel   Direction  Beat contents
// cmd_i     in         action, focus_q8, current_ma: one frame request
// frame_o   out        frame_byte, last_byte: one frame byte, last flagged
// cfg_*_i   in         write enable, register index, data
//
// A request is held in the divider (two quotient bits per cycle), and
// no new request is taken while the divider is busy.
// A focus frame leaves as 10 beats and a current frame as 6, one per cycle
// while frame_o is ready, as the output register sets one byte per cycle
// unless a stalled receiver holds it.
// Reset (rst_ni low) clears all control state and loads default limits.
// A two-entry queue between divider and byte sequencer lets each stall alone.
module lens_command_frame_builder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lcfb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lcfb_pkg::CfgDataW-1:0]  cfg_data_i,
  lcfb_cmd_if.sink                       cmd_i,
  lcfb_frame_if.source                   frame_o
);
  import lcfb_pkg::*;

  lcfb_cfg_t cfg_q;
  logic      push, push_ready, q_valid, pop;
  lcfb_job_t push_job, q_job;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.focus_min  <= FocusMinReset;
      cfg_q.focus_max  <= FocusMaxReset;
      cfg_q.full_scale <= FullScaleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFocusMin:  cfg_q.focus_min  <= cfg_data_i;
        CfgFocusMax:  cfg_q.focus_max  <= cfg_data_i;
        CfgFullScale: cfg_q.full_scale <= cfg_data_i[CurrentW-1:0];
        default:      ;
      endcase
    end
  end

  lcfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd_i),
    .push_o       (push),
    .job_o        (push_job),
    .push_ready_i (push_ready)
  );

  lcfb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_job),
    .push_ready_o (push_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_job),
    .pop_i        (pop)
  );

  lcfb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_job),
    .pop_o     (pop),
    .frame_o   (frame_o)
  );

endmodule

FILE: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcfb_pkg::*;

  // Unused register slot: writes to it must leave every limit alone.
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  // One frame request as the command channel carries it.
  typedef struct packed {
    logic                action;
    logic [FocusW-1:0]   focus_q8;
    logic [CurrentW-1:0] current_ma;
  } lens_cmd_t;

  // One frame byte still owed by the block.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } frame_beat_t;

  typedef enum logic {RowItem, RowReg} row_kind_e;

  // One line of the directed stimulus: a request, or a register write.
  typedef struct packed {
    row_kind_e           kind;
    lens_cmd_t           cmd;
    logic                has_code;
    logic [CodeW-1:0]    code;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_data;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  lcfb_cmd_if   cmd_if ();
  lcfb_frame_if frame_if ();

  lens_command_frame_builder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_if),
    .frame_o    (frame_if)
  );

  always #5 clk_i = ~clk_i;

  // Local copy of the limits, updated as they are written.
  logic [FocusW-1:0]   focus_lo;
  logic [FocusW-1:0]   focus_hi;
  logic [CurrentW-1:0] full_scale_ma;

  frame_beat_t frame_bytes_due[$];
  stim_row_t   stim_table[$];
  int unsigned errors  = 0;
  bit          idle_on = 1'b1;

  // Focus code: clamp against the upper limit first, then the lower one.
  function automatic logic [CodeW-1:0] focus_code_of(input logic [FocusW-1:0] f);
    logic [FocusW-1:0] fc;
    logic [31:0]       v;
    fc = f;
    if (f > focus_hi) begin
      fc = focus_hi;
    end else if (f < focus_lo) begin
      fc = focus_lo;
    end
    if (fc == '0) return CodeMax;
    v = 32'd1000 + 32'd51200000 / {16'd0, fc};
    return (v > 32'h0000_FFFF) ? CodeMax : v[CodeW-1:0];
  endfunction

  function automatic logic [CodeW-1:0] current_code_of(input logic [CurrentW-1:0] c);
    logic [31:0] v;
    if (full_scale_ma == '0) return CodeMax;
    v = ({22'd0, c} * 32'd4096) / {22'd0, full_scale_ma};
    return (v > 32'h0000_FFFF) ? CodeMax : v[CodeW-1:0];
  endfunction

  // Lay out the whole frame for a code, append the CRC-16/ARC and queue its bytes.
  function automatic void queue_frame(input logic action, input logic [CodeW-1:0] code);
    logic [ByteW-1:0] body[$];
    logic [15:0]      crc;
    if (action == ActFocus) begin
      body.push_back(8'h50);
      body.push_back(8'h77);
      body.push_back(8'h44);
      body.push_back(8'h41);
      body.push_back(code[15:8]);
      body.push_back(code[7:0]);
      body.push_back(8'h00);
      body.push_back(8'h00);
    end else begin
      body.push_back(8'h41);
      body.push_back(8'h77);
      body.push_back(code[15:8]);
      body.push_back(code[7:0]);
    end
    crc = 16'h0000;
    foreach (body[i]) begin
      crc = crc ^ {8'h00, body[i]};
      repeat (8) crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
    end
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    foreach (body[i]) begin
      frame_bytes_due.push_back('{data: body[i], last: (i == body.size() - 1)});
    end
  endfunction

  function automatic stim_row_t item_row(input logic action, input logic [FocusW-1:0] f,
                                         input logic [CurrentW-1:0] c,
                                         input logic has_code, input logic [CodeW-1:0] code);
    stim_row_t r;
    r          = '0;
    r.kind     = RowItem;
    r.cmd      = '{action: action, focus_q8: f, current_ma: c};
    r.has_code = has_code;
    r.code     = code;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgDataW-1:0] data);
    stim_row_t r;
    r          = '0;
    r.kind     = RowReg;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  // Random request, biased toward the clamp limits and the saturating range.
  function automatic lens_cmd_t random_cmd();
    lens_cmd_t cmd;
    cmd.action     = 1'($urandom_range(0, 1));
    cmd.current_ma = 10'($urandom_range(0, 1023));
    case ($urandom_range(0, 4))
      0:       cmd.focus_q8 = focus_lo + 16'($urandom_range(0, 4)) - 16'd2;
      1:       cmd.focus_q8 = focus_hi + 16'($urandom_range(0, 4)) - 16'd2;
      2:       cmd.focus_q8 = 16'($urandom_range(0, 900));
      default: cmd.focus_q8 = 16'($urandom_range(0, 65535));
    endcase
    if ($urandom_range(0, 7) == 0) begin
      cmd.current_ma = full_scale_ma + 10'($urandom_range(0, 2)) - 10'd1;
    end
    return cmd;
  endfunction

  // Register write, one per clock; the caller lowers the write enable.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CfgFocusMin:  focus_lo      = data;
      CfgFocusMax:  focus_hi      = data;
      CfgFullScale: full_scale_ma = data[CurrentW-1:0];
      default:      ;
    endcase
    @(posedge clk_i);
  endtask

  // Stop sending and wait until every owed byte has come out.
  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_limits(input logic [FocusW-1:0] lo, input logic [FocusW-1:0] hi,
                             input logic [CurrentW-1:0] fs);
    drain();
    write_reg(CfgFocusMin, lo);
    write_reg(CfgFocusMax, hi);
    write_reg(CfgFullScale, {6'd0, fs});
    cfg_we_i <= 1'b0;
  endtask

  // Offer one request, with random gaps while idle_on is set, and predict its frame once it is taken.
  task automatic send_cmd(input lens_cmd_t cmd, input logic has_code,
                          input logic [CodeW-1:0] code);
    while (idle_on && $urandom_range(0, 99) < 19) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.action     <= cmd.action;
    cmd_if.focus_q8   <= cmd.focus_q8;
    cmd_if.current_ma <= cmd.current_ma;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    if (has_code) begin
      queue_frame(cmd.action, code);
    end else if (cmd.action == ActFocus) begin
      queue_frame(ActFocus, focus_code_of(cmd.focus_q8));
    end else begin
      queue_frame(ActCurrent, current_code_of(cmd.current_ma));
    end
  endtask

  // Frame side: random back-pressure while idle_on is set, and each accepted beat checked in order.
  initial begin
    frame_beat_t exp_beat;
    frame_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && frame_if.valid === 1'b1 && frame_if.ready === 1'b1) begin
        if (frame_bytes_due.size() == 0) begin
          errors++;
          if (errors <= 40) begin
            $display("%0t: unexpected beat, expected none, got byte %02h last %0b",
                     $time, frame_if.frame_byte, frame_if.last_byte);
          end
        end else begin
          exp_beat = frame_bytes_due.pop_front();
          if (frame_if.frame_byte !== exp_beat.data) begin
            errors++;
            if (errors <= 40) begin
              $display("%0t: frame_byte mismatch, expected %02h, got %02h",
                       $time, exp_beat.data, frame_if.frame_byte);
            end
          end
          if (frame_if.last_byte !== exp_beat.last) begin
            errors++;
            if (errors <= 40) begin
              $display("%0t: last_byte mismatch, expected %0b, got %0b",
                       $time, exp_beat.last, frame_if.last_byte);
            end
          end
        end
      end
      frame_if.ready <= !idle_on || ($urandom_range(0, 99) >= 19);
    end
  end

  // Main sequence: reset, directed table, then random phases under varied limits.
  initial begin
    lens_cmd_t     cmd;
    logic [15:0]   lo;
    logic [15:0]   hi;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CfgFocusMin;
    cfg_data_i        <= '0;
    cmd_if.valid      <= 1'b0;
    cmd_if.action     <= ActFocus;
    cmd_if.focus_q8   <= '0;
    cmd_if.current_ma <= '0;
    focus_lo      = 16'd23040;
    focus_hi      = 16'd40960;
    full_scale_ma = 10'd293;

    // Default limits: clamping at both ends and the plain current mapping.
    stim_table.push_back(item_row(ActFocus, 16'd0, 10'd0, 1'b1, 16'd3222));
    stim_table.push_back(item_row(ActFocus, 16'hFFFF, 10'd0, 1'b1, 16'd2250));
    stim_table.push_back(item_row(ActFocus, 16'd23040, 10'd0, 1'b1, 16'd3222));
    stim_table.push_back(item_row(ActFocus, 16'd40960, 10'd0, 1'b1, 16'd2250));
    stim_table.push_back(item_row(ActFocus, 16'hAAAA, 10'h155, 1'b1, 16'd2250));
    stim_table.push_back(item_row(ActFocus, 16'h5555, 10'h2AA, 1'b1, 16'd3222));
    stim_table.push_back(item_row(ActFocus, 16'd30000, 10'd0, 1'b0, '0));
    stim_table.push_back(item_row(ActCurrent, 16'hFFFF, 10'd0, 1'b1, 16'd0));
    stim_table.push_back(item_row(ActCurrent, 16'd0, 10'd293, 1'b1, 16'd4096));
    stim_table.push_back(item_row(ActCurrent, 16'd0, 10'd1023, 1'b0, '0));
    stim_table.push_back(item_row(ActCurrent, 16'h5555, 10'h2AA, 1'b0, '0));
    stim_table.push_back(item_row(ActCurrent, 16'hAAAA, 10'h155, 1'b0, '0));
    // Open limits and unit full scale: zero focus and oversized codes saturate.
    stim_table.push_back(reg_row(CfgFocusMin, 16'd0));
    stim_table.push_back(reg_row(CfgFocusMax, 16'hFFFF));
    stim_table.push_back(reg_row(CfgFullScale, 16'd1));
    stim_table.push_back(item_row(ActFocus, 16'd0, 10'd0, 1'b1, CodeMax));
    stim_table.push_back(item_row(ActFocus, 16'd793, 10'd0, 1'b1, CodeMax));
    stim_table.push_back(item_row(ActFocus, 16'd794, 10'd0, 1'b0, '0));
    stim_table.push_back(item_row(ActFocus, 16'hFFFF, 10'd0, 1'b0, '0));
    stim_table.push_back(item_row(ActCurrent, 16'd0, 10'd1, 1'b1, 16'd4096));
    stim_table.push_back(item_row(ActCurrent, 16'd0, 10'd1023, 1'b1, CodeMax));
    // Zero full scale saturates even for zero current.
    stim_table.push_back(reg_row(CfgFullScale, 16'd0));
    stim_table.push_back(item_row(ActCurrent, 16'd0, 10'd0, 1'b1, CodeMax));
    // Upper data bits of the full scale are dropped; the spare slot is ignored.
    stim_table.push_back(reg_row(CfgFullScale, 16'hFFFF));
    stim_table.push_back(reg_row(CfgSpare, 16'hFFFF));
    stim_table.push_back(item_row(ActCurrent, 16'd0, 10'd1023, 1'b1, 16'd4096));
    // Crossed limits: the upper test wins, everything else below goes to the minimum.
    stim_table.push_back(reg_row(CfgFocusMin, 16'd40000));
    stim_table.push_back(reg_row(CfgFocusMax, 16'd30000));
    stim_table.push_back(item_row(ActFocus, 16'd50000, 10'd0, 1'b1, 16'd2706));
    stim_table.push_back(item_row(ActFocus, 16'd35000, 10'd0, 1'b1, 16'd2706));
    stim_table.push_back(item_row(ActFocus, 16'd20000, 10'd0, 1'b1, 16'd2280));
    stim_table.push_back(item_row(ActFocus, 16'd0, 10'd0, 1'b1, 16'd2280));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == RowReg) begin
        drain();
        write_reg(stim_table[i].reg_idx, stim_table[i].reg_data);
      end else begin
        cfg_we_i <= 1'b0;
        send_cmd(stim_table[i].cmd, stim_table[i].has_code, stim_table[i].code);
      end
    end

    // Random phases of 60 requests, each under its own limits.
    for (int ph = 0; ph < 6; ph++) begin
      idle_on = 1'b1;
      case (ph)
        0: load_limits(FocusMinReset, FocusMaxReset, FullScaleReset);
        1, 3: begin
          lo = 16'($urandom_range(0, 40000));
          hi = 16'($urandom_range(lo, 65535));
          load_limits(lo, hi, 10'($urandom_range(64, 1023)));
        end
        2: load_limits(16'd0, 16'hFFFF, 10'd64);
        4: begin
          hi = 16'($urandom_range(0, 30000));
          lo = 16'($urandom_range(hi + 1, 65535));
          load_limits(lo, hi, 10'd1023);
        end
        default: begin
          load_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      10'($urandom_range(0, 1023)));
        end
      endcase
      // One phase runs with both sides at full rate.
      if (ph == 3) idle_on = 1'b0;
      repeat (60) begin
        cmd = random_cmd();
        send_cmd(cmd, 1'b0, '0);
      end
    end

    drain();
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
